// ===== src/pfpm_pkg.sv =====
// Shared types and constants for the power factor phase meter.
package pfpm_pkg;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;
    localparam int SUM_W = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [29:0] FREQ_NUM = 30'd1000000000;
    localparam logic [15:0] FULL_TURN = 16'd36000;
    localparam logic [31:0] RAD_SCALE = 32'd187403;
    localparam logic [31:0] COS_C4 = 32'd26630;
    localparam logic [31:0] COS_C3 = 32'd1491308;
    localparam logic [31:0] COS_C2 = 32'd44739243;
    localparam logic [31:0] COS_C1 = 32'd536870912;
    localparam logic [31:0] Q30_ONE = 32'd1073741824;

    typedef enum logic [1:0] {
        REG_WINDOW  = 2'd0,
        REG_VOFFSET = 2'd1,
        REG_IOFFSET = 2'd2,
        REG_FLOOR   = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_FREQ,
        DIV_PHASE,
        DIV_MOD
    } div_sel_t;

    typedef enum logic [2:0] {
        COS_RAD,
        COS_SQR,
        COS_H4,
        COS_H3,
        COS_H2,
        COS_H1,
        COS_FIN
    } cos_step_t;

    typedef struct packed {
        logic      item;
        logic      div_start;
        div_sel_t  div_sel;
        logic      mean_load;
        logic      freq_load;
        logic      phase_load;
        logic      mod_load;
        logic      cos_en;
        cos_step_t cos_step;
        logic      out_load;
    } pfpm_cmd_t;

    typedef struct packed {
        logic win_end;
        logic count_zero;
        logic mean_zero;
        logic div_done;
        logic out_free;
    } pfpm_stat_t;

endpackage

// ===== src/pfpm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pfpm_div
    import pfpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output logic [DIV_DW-1:0] remainder,
    output logic              done
);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic [6:0]        cnt_reg;
    logic              done_reg;
    logic [DIV_DW:0]   rem_shift;
    logic [DIV_DW+1:0] diff;
    logic              ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIV_NW-1]};
        diff = {1'b0, rem_shift} - {2'b00, dsr_reg};
        ge = !diff[DIV_DW+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 7'd1);
            if (start)
                cnt_reg <= 7'(DIV_NW);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], ge};
            rem_reg <= ge ? diff[DIV_DW-1:0] : rem_shift[DIV_DW-1:0];
        end
    end

    assign quotient = quo_reg;
    assign remainder = rem_reg;
    assign done = done_reg;

endmodule

// ===== src/pfpm_datapath.sv =====
// Datapath: crossing tracker, window sums, result arithmetic and output register.
module pfpm_datapath
    import pfpm_pkg::*;
#(
    parameter int ADC_BITS = 10,
    parameter int PERIOD_BITS = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pfpm_cmd_t                 cmd,
    output pfpm_stat_t                stat,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    input  logic [ADC_BITS-1:0]       voltage_code,
    input  logic [ADC_BITS-1:0]       current_code,
    input  logic [31:0]               time_us,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [23:0]               mean_period_us,
    output logic [29:0]               frequency_mhz,
    output logic [15:0]               phase_centideg,
    output logic signed [15:0]        power_factor_q15,
    output logic [15:0]               cycles_seen,
    output logic                      result_valid
);

    localparam int VW = ((ADC_BITS > 10) ? ADC_BITS : 10) + 2;
    localparam logic [VW-1:0] MID = VW'(1) << (ADC_BITS - 1);
    localparam logic [31:0] PMAX = 32'((64'd1 << PERIOD_BITS) - 64'd1);

    typedef enum logic [1:0] {
        PH_HIGH = 2'd0,
        PH_LOW  = 2'd1,
        PH_POS  = 2'd2,
        PH_WAIT = 2'd3
    } xphase_t;

    logic [15:0]              win_reg;
    logic signed [9:0]        voff_reg;
    logic signed [9:0]        ioff_reg;
    logic [15:0]              floor_reg;

    xphase_t                  phase_reg, phase_next;
    logic [31:0]              start_reg, start_next;
    logic signed [VW-1:0]     vpk_reg, vpk_next;
    logic signed [VW-1:0]     ipk_reg, ipk_next;
    logic [31:0]              vpt_reg, vpt_next;
    logic [31:0]              ipt_reg, ipt_next;
    logic [PERIOD_BITS-1:0]   lgl_reg, lgl_next;
    logic [SUM_W-1:0]         psum_reg, psum_next;
    logic [SUM_W-1:0]         lsum_reg, lsum_next;
    logic [15:0]              cnt_reg, cnt_next;
    logic [15:0]              pos_reg;

    logic [SUM_W-1:0]         psum_snap;
    logic [SUM_W-1:0]         lsum_snap;
    logic [15:0]              cnt_snap;

    logic signed [VW-1:0]     v;
    logic signed [VW-1:0]     i;
    logic [31:0]              period_raw;
    logic [31:0]              period_sat;
    logic signed [32:0]       lag;
    logic [31:0]              lag_used;
    logic [SUM_W:0]           psum_add;
    logic [SUM_W:0]           lsum_add;
    logic [16:0]              pos_inc;
    logic [16:0]              limit;

    logic [DIV_NW-1:0]        div_dividend;
    logic [DIV_DW-1:0]        div_divisor;
    logic [DIV_NW-1:0]        div_quo;
    logic [DIV_DW-1:0]        div_rem;
    logic                     div_done;

    logic [23:0]              mean_reg;
    logic [29:0]              freq_reg;
    logic [15:0]              phase_cd_reg;
    logic [DIV_DW-1:0]        qtmp_reg;
    logic [63:0]              prod_reg;
    logic [31:0]              x2_reg;
    logic signed [15:0]       pf_reg;
    logic [31:0]              mul_a;
    logic [31:0]              mul_b;
    logic [13:0]              cf;
    logic                     cneg;
    logic signed [34:0]       tf;
    logic [30:0]              tcl;
    logic [15:0]              rnd;
    logic [15:0]              pf_mag;

    logic                     oval_reg;
    logic [23:0]              omean_reg;
    logic [29:0]              ofreq_reg;
    logic [15:0]              ophase_reg;
    logic signed [15:0]       opf_reg;
    logic [15:0]              ocyc_reg;
    logic                     ores_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 16'd1000;
            voff_reg <= '0;
            ioff_reg <= '0;
            floor_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW:  win_reg <= cfg_data;
                REG_VOFFSET: voff_reg <= cfg_data[9:0];
                REG_IOFFSET: ioff_reg <= cfg_data[9:0];
                REG_FLOOR:   floor_reg <= cfg_data;
                default:     win_reg <= win_reg;
            endcase
        end
    end

    // crossing machine and period accounting for one transaction
    always_comb
    begin
        v = $signed({{(VW-ADC_BITS){1'b0}}, voltage_code}) - $signed(MID)
            + $signed(VW'(voff_reg));
        i = $signed({{(VW-ADC_BITS){1'b0}}, current_code}) - $signed(MID)
            + $signed(VW'(ioff_reg));
        phase_next = phase_reg;
        start_next = start_reg;
        vpk_next = vpk_reg;
        ipk_next = ipk_reg;
        vpt_next = vpt_reg;
        ipt_next = ipt_reg;
        lgl_next = lgl_reg;
        psum_next = psum_reg;
        lsum_next = lsum_reg;
        cnt_next = cnt_reg;
        period_raw = time_us - start_reg;
        period_sat = (period_raw > PMAX) ? PMAX : period_raw;
        lag = '0;
        lag_used = '0;
        psum_add = '0;
        lsum_add = '0;

        if (v > 0 && phase_next == PH_WAIT)
            phase_next = PH_HIGH;
        if (v <= 0 && phase_next == PH_HIGH)
        begin
            start_next = time_us;
            phase_next = PH_LOW;
        end
        if (v > 0 && phase_next == PH_LOW)
        begin
            phase_next = PH_POS;
            vpk_next = '0;
            ipk_next = '0;
        end
        if (v > vpk_next && phase_next == PH_POS)
        begin
            vpk_next = v;
            vpt_next = time_us;
        end
        if (i > ipk_next && phase_next == PH_POS)
        begin
            ipk_next = i;
            ipt_next = time_us;
        end
        if (v <= 0 && phase_next == PH_POS)
        begin
            lag = $signed({1'b0, ipt_next - start_reg})
                - $signed({1'b0, vpt_next - start_reg});
            if (lag >= $signed({17'd0, floor_reg}))
            begin
                lag_used = (lag[31:0] > PMAX) ? PMAX : lag[31:0];
                lgl_next = lag_used[PERIOD_BITS-1:0];
            end
            else
                lag_used = 32'(lgl_reg);
            psum_add = {1'b0, psum_reg} + (SUM_W+1)'(period_sat);
            lsum_add = {1'b0, lsum_reg} + (SUM_W+1)'(lag_used);
            psum_next = psum_add[SUM_W] ? SUM_MAX : psum_add[SUM_W-1:0];
            lsum_next = lsum_add[SUM_W] ? SUM_MAX : lsum_add[SUM_W-1:0];
            if (cnt_reg != 16'hFFFF)
                cnt_next = cnt_reg + 16'd1;
            start_next = time_us;
            phase_next = PH_LOW;
            vpk_next = '0;
            ipk_next = '0;
        end
        pos_inc = {1'b0, pos_reg} + 17'd1;
        limit = (win_reg == '0) ? 17'd1 : {1'b0, win_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            start_reg <= '0;
            vpk_reg <= '0;
            ipk_reg <= '0;
            vpt_reg <= '0;
            ipt_reg <= '0;
            lgl_reg <= '0;
            psum_reg <= '0;
            lsum_reg <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else if (cmd.item)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            vpk_reg <= vpk_next;
            ipk_reg <= ipk_next;
            vpt_reg <= vpt_next;
            ipt_reg <= ipt_next;
            lgl_reg <= lgl_next;
            if (pos_inc >= limit)
            begin
                psum_reg <= '0;
                lsum_reg <= '0;
                cnt_reg <= '0;
                pos_reg <= '0;
            end
            else
            begin
                psum_reg <= psum_next;
                lsum_reg <= lsum_next;
                cnt_reg <= cnt_next;
                pos_reg <= pos_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item && pos_inc >= limit)
        begin
            psum_snap <= psum_next;
            lsum_snap <= lsum_next;
            cnt_snap <= cnt_next;
        end
    end

    // divider operands; phase is (lag_sum mod period_sum) * 36000 / period_sum,
    // which already lies within one turn
    always_comb
    begin
        case (cmd.div_sel)
            DIV_MEAN:
            begin
                div_dividend = DIV_NW'(psum_snap);
                div_divisor = DIV_DW'(cnt_snap);
            end
            DIV_FREQ:
            begin
                div_dividend = DIV_NW'(FREQ_NUM);
                div_divisor = DIV_DW'(mean_reg);
            end
            DIV_PHASE:
            begin
                div_dividend = DIV_NW'(lsum_snap);
                div_divisor = psum_snap;
            end
            DIV_MOD:
            begin
                div_dividend = DIV_NW'(qtmp_reg) * DIV_NW'(FULL_TURN);
                div_divisor = psum_snap;
            end
            default:
            begin
                div_dividend = '0;
                div_divisor = '0;
            end
        endcase
    end

    pfpm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mean_load)
        begin
            mean_reg <= (div_quo > DIV_NW'(24'hFFFFFF)) ? 24'hFFFFFF : div_quo[23:0];
            phase_cd_reg <= '0;
        end
        if (cmd.freq_load)
            freq_reg <= (mean_reg == '0) ? FREQ_NUM : div_quo[29:0];
        if (cmd.phase_load)
            qtmp_reg <= div_rem;
        if (cmd.mod_load)
            phase_cd_reg <= div_quo[15:0];
    end

    // cosine: quadrant fold, then Horner steps through one shared multiplier
    always_comb
    begin
        cneg = 1'b0;
        if (phase_cd_reg <= 16'd9000)
            cf = phase_cd_reg[13:0];
        else if (phase_cd_reg <= 16'd18000)
        begin
            cf = 14'(16'd18000 - phase_cd_reg);
            cneg = 1'b1;
        end
        else if (phase_cd_reg <= 16'd27000)
        begin
            cf = 14'(phase_cd_reg - 16'd18000);
            cneg = 1'b1;
        end
        else
            cf = 14'(FULL_TURN - phase_cd_reg);

        case (cmd.cos_step)
            COS_RAD:
            begin
                mul_a = 32'(cf);
                mul_b = RAD_SCALE;
            end
            COS_SQR:
            begin
                mul_a = prod_reg[31:0];
                mul_b = prod_reg[31:0];
            end
            COS_H4:
            begin
                mul_a = prod_reg[61:30];
                mul_b = COS_C4;
            end
            COS_H3:
            begin
                mul_a = x2_reg;
                mul_b = COS_C3 - prod_reg[61:30];
            end
            COS_H2:
            begin
                mul_a = x2_reg;
                mul_b = COS_C2 - prod_reg[61:30];
            end
            COS_H1:
            begin
                mul_a = x2_reg;
                mul_b = COS_C1 - prod_reg[61:30];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        tf = $signed(35'(Q30_ONE)) - $signed({1'b0, prod_reg[63:30]});
        if (tf < 0)
            tcl = '0;
        else if (tf > $signed(35'(Q30_ONE)))
            tcl = Q30_ONE[30:0];
        else
            tcl = tf[30:0];
        rnd = 16'((32'(tcl) + 32'd16384) >> 15);
        pf_mag = (rnd > 16'd32767) ? 16'd32767 : rnd;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cos_en)
        begin
            prod_reg <= 64'(mul_a) * 64'(mul_b);
            if (cmd.cos_step == COS_H4)
                x2_reg <= prod_reg[61:30];
            if (cmd.cos_step == COS_FIN)
                pf_reg <= cneg ? -$signed(pf_mag) : $signed(pf_mag);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oval_reg <= 1'b0;
        else if (cmd.out_load)
            oval_reg <= 1'b1;
        else if (out_ready)
            oval_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ores_reg <= (cnt_snap != '0);
            ocyc_reg <= cnt_snap;
            if (cnt_snap != '0)
            begin
                omean_reg <= mean_reg;
                ofreq_reg <= freq_reg;
                ophase_reg <= phase_cd_reg;
                opf_reg <= pf_reg;
            end
            else
            begin
                omean_reg <= '0;
                ofreq_reg <= '0;
                ophase_reg <= '0;
                opf_reg <= '0;
            end
        end
    end

    assign out_valid = oval_reg;
    assign mean_period_us = omean_reg;
    assign frequency_mhz = ofreq_reg;
    assign phase_centideg = ophase_reg;
    assign power_factor_q15 = opf_reg;
    assign cycles_seen = ocyc_reg;
    assign result_valid = ores_reg;

    assign stat.win_end = (pos_inc >= limit);
    assign stat.count_zero = (cnt_snap == '0);
    assign stat.mean_zero = (mean_reg == '0);
    assign stat.div_done = div_done;
    assign stat.out_free = !oval_reg || out_ready;

endmodule

// ===== src/pfpm_ctrl.sv =====
// Controller: sample intake and the window-end computation sequence.
module pfpm_ctrl
    import pfpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pfpm_stat_t stat,
    output pfpm_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MEAN_W,
        S_FREQ,
        S_FREQ_W,
        S_PH,
        S_PH_W,
        S_MOD,
        S_MOD_W,
        S_COS,
        S_OUT
    } state_t;

    state_t    state_reg, state_next;
    cos_step_t cos_reg, cos_next;

    always_comb
    begin
        state_next = state_reg;
        cos_next = cos_reg;
        cmd = '0;
        cmd.div_sel = DIV_MEAN;
        cmd.cos_step = cos_reg;
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.item = 1'b1;
                    if (stat.win_end)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.count_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel = DIV_MEAN;
                    state_next = S_MEAN_W;
                end
            end
            S_MEAN_W:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_load = 1'b1;
                    state_next = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (stat.mean_zero)
                begin
                    cmd.freq_load = 1'b1;
                    cos_next = COS_RAD;
                    state_next = S_COS;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel = DIV_FREQ;
                    state_next = S_FREQ_W;
                end
            end
            S_FREQ_W:
            begin
                if (stat.div_done)
                begin
                    cmd.freq_load = 1'b1;
                    state_next = S_PH;
                end
            end
            S_PH:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = DIV_PHASE;
                state_next = S_PH_W;
            end
            S_PH_W:
            begin
                if (stat.div_done)
                begin
                    cmd.phase_load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = DIV_MOD;
                state_next = S_MOD_W;
            end
            S_MOD_W:
            begin
                if (stat.div_done)
                begin
                    cmd.mod_load = 1'b1;
                    cos_next = COS_RAD;
                    state_next = S_COS;
                end
            end
            S_COS:
            begin
                cmd.cos_en = 1'b1;
                if (cos_reg == COS_FIN)
                    state_next = S_OUT;
                else
                    cos_next = cos_step_t'(cos_reg + 3'd1);
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cos_reg <= COS_RAD;
        end
        else
        begin
            state_reg <= state_next;
            cos_reg <= cos_next;
        end
    end

endmodule

// ===== src/power_factor_phase_meter.sv =====
// Power factor and line frequency meter, top level.
//
// Each sample transaction updates the crossing tracker and the window
// sums. The transaction that closes a window starts the result sequence:
// up to four passes of the shared restoring divider, each begun by a start
// (mean period, frequency, lag sum modulo period sum, that remainder scaled
// to one turn), then seven steps of the shared cosine multiplier and a load
// of the output register. Input is held off after such a transaction until
// the sequence has ended and any earlier result still unread has been taken;
// the sequence is shorter when the mean period is zero and shorter still
// when no period completed. The result waits in an output register,
// so sampling resumes while it is still unread. Configuration writes are
// taken in any cycle and apply to the next sample.
module power_factor_phase_meter
    import pfpm_pkg::*;
#(
    parameter int ADC_BITS = 10,
    parameter int PERIOD_BITS = 24
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // voltage_code, current_code, time_us
    input  logic [((2*ADC_BITS+32+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mean_period_us, frequency_mhz, phase_centideg, power_factor_q15, cycles_seen
    output logic [103:0]                        m_axis_tdata,
    // result_valid
    output logic                                m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_data
);

    pfpm_cmd_t          cmd;
    pfpm_stat_t         stat;
    logic [23:0]        mean_period_us;
    logic [29:0]        frequency_mhz;
    logic [15:0]        phase_centideg;
    logic signed [15:0] power_factor_q15;
    logic [15:0]        cycles_seen;

    pfpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pfpm_datapath #(
        .ADC_BITS    (ADC_BITS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .voltage_code     (s_axis_tdata[ADC_BITS-1:0]),
        .current_code     (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
        .time_us          (s_axis_tdata[2*ADC_BITS+31:2*ADC_BITS]),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .mean_period_us   (mean_period_us),
        .frequency_mhz    (frequency_mhz),
        .phase_centideg   (phase_centideg),
        .power_factor_q15 (power_factor_q15),
        .cycles_seen      (cycles_seen),
        .result_valid     (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, cycles_seen, power_factor_q15, phase_centideg,
                           frequency_mhz, mean_period_us};

endmodule

// ===== bench/testbench.sv =====
// Testbench for the power factor phase meter: stimulus, result prediction and checking.
`timescale 1ns / 1ps

module testbench;
    import pfpm_pkg::*;

    localparam int ADC_BITS = 10;
    localparam int PERIOD_BITS = 24;
    localparam int IN_W = ((2*ADC_BITS+32+7)/8)*8;
    localparam logic [63:0] PERIOD_MAX = (64'd1 << PERIOD_BITS) - 1;
    localparam logic [63:0] SUM_LIMIT = (64'd1 << 40) - 1;

    typedef struct packed {
        logic [31:0] time_us;
        logic [9:0]  current_code;
        logic [9:0]  voltage_code;
    } sample_t;

    typedef struct packed {
        logic [15:0] cycles_seen;
        logic [15:0] power_factor_q15;
        logic [15:0] phase_centideg;
        logic [29:0] frequency_mhz;
        logic [23:0] mean_period_us;
        logic        result_valid;
    } reading_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [103:0] m_axis_tdata;
    logic m_axis_tuser;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    power_factor_phase_meter u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] win_len;
    logic signed [31:0] v_off, i_off;
    logic [15:0] lag_floor;
    logic [1:0] xphase;
    logic [31:0] t_start, t_vpk, t_ipk;
    logic signed [31:0] v_pk, i_pk;
    logic [63:0] good_lag, per_sum, lag_acc;
    logic [15:0] per_cnt, win_pos;

    sample_t pending_samples[$];
    reading_t expected_readings[$];
    int errors = 0;
    int readings_seen = 0;
    int samples_sent = 0;
    bit stim_done = 0;
    bit hold_off = 0;
    bit in_taken = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic logic [15:0] cos_q15_quadrant(input logic [31:0] c);
        logic [63:0] rad, x2, t;
        rad = 64'(c) * 64'd187403;
        x2 = (rad * rad) >> 30;
        t = 64'd26630;
        t = 64'd1491308 - ((x2 * t) >> 30);
        t = 64'd44739243 - ((x2 * t) >> 30);
        t = 64'd536870912 - ((x2 * t) >> 30);
        t = 64'd1073741824 - ((x2 * t) >> 30);
        if ($signed(t) < 0) t = 0;
        if ($signed(t) > 64'sd1073741824) t = 64'd1073741824;
        t = (t + 64'd16384) >> 15;
        if (t > 64'd32767) t = 64'd32767;
        return t[15:0];
    endfunction

    function automatic logic [15:0] cos_q15(input logic [31:0] c);
        if (c <= 9000) return cos_q15_quadrant(c);
        if (c <= 18000) return -cos_q15_quadrant(18000 - c);
        if (c <= 27000) return -cos_q15_quadrant(c - 18000);
        return cos_q15_quadrant(36000 - c);
    endfunction

    task automatic reset_meter_model();
        win_len = 1000; v_off = 0; i_off = 0; lag_floor = 100;
        xphase = 3; t_start = 0; v_pk = 0; i_pk = 0; t_vpk = 0; t_ipk = 0;
        good_lag = 0; per_sum = 0; lag_acc = 0; per_cnt = 0; win_pos = 0;
    endtask

    task automatic measure_sample(input sample_t s);
        logic signed [31:0] v, i;
        logic [63:0] period, used, mean, freq, phase;
        logic signed [63:0] lag;
        logic [15:0] lim;
        reading_t r;
        v = $signed({22'd0, s.voltage_code}) - 512 + v_off;
        i = $signed({22'd0, s.current_code}) - 512 + i_off;
        if (v > 0 && xphase == 3) xphase = 0;
        if (v <= 0 && xphase == 0)
        begin
            t_start = s.time_us; xphase = 1;
        end
        if (v > 0 && xphase == 1)
        begin
            xphase = 2; v_pk = 0; i_pk = 0;
        end
        if (v > v_pk && xphase == 2)
        begin
            v_pk = v; t_vpk = s.time_us;
        end
        if (i > i_pk && xphase == 2)
        begin
            i_pk = i; t_ipk = s.time_us;
        end
        if (v <= 0 && xphase == 2)
        begin
            period = 64'(32'(s.time_us - t_start));
            lag = $signed(64'(32'(t_ipk - t_start))) - $signed(64'(32'(t_vpk - t_start)));
            if (period > PERIOD_MAX) period = PERIOD_MAX;
            if (lag >= $signed(64'(lag_floor)))
            begin
                used = lag;
                if (used > PERIOD_MAX) used = PERIOD_MAX;
                good_lag = used;
            end
            else
                used = good_lag;
            per_sum = per_sum + period;
            if (per_sum > SUM_LIMIT) per_sum = SUM_LIMIT;
            lag_acc = lag_acc + used;
            if (lag_acc > SUM_LIMIT) lag_acc = SUM_LIMIT;
            if (per_cnt != 16'hFFFF) per_cnt++;
            t_start = s.time_us; xphase = 1; v_pk = 0; i_pk = 0;
        end
        win_pos++;
        lim = (win_len == 0) ? 16'd1 : win_len;
        if (win_pos < lim) return;
        r = '0;
        if (per_cnt > 0)
        begin
            mean = per_sum / per_cnt;
            if (mean > 64'hFFFFFF) mean = 64'hFFFFFF;
            freq = (mean == 0) ? 64'd1000000000 : 64'd1000000000 / mean;
            phase = 0;
            if (mean != 0 && per_sum != 0) phase = ((lag_acc * 36000) / per_sum) % 36000;
            r.mean_period_us = mean[23:0];
            r.frequency_mhz = freq[29:0];
            r.phase_centideg = phase[15:0];
            r.power_factor_q15 = cos_q15(phase[31:0]);
            r.cycles_seen = per_cnt;
            r.result_valid = 1;
        end
        expected_readings.push_back(r);
        win_pos = 0; per_sum = 0; lag_acc = 0; per_cnt = 0;
    endtask

    // driver: bursts and gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_taken)
            begin
                in_taken = 0;
                if (gap_left > 0 || hold_off || pending_samples.size() == 0)
                begin
                    if (gap_left > 0) gap_left--;
                    s_axis_tvalid <= 0;
                end
                else
                begin
                    s_axis_tdata <= IN_W'(pending_samples.pop_front());
                    s_axis_tvalid <= 1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver stall pattern
    int stall_mode = 0;
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // predict on accepted input, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            measure_sample(sample_t'(s_axis_tdata[51:0]));
            samples_sent++;
            in_taken = 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            reading_t got, want;
            got = {m_axis_tdata[101:0], m_axis_tuser};
            readings_seen++;
            if (expected_readings.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.result_valid !== want.result_valid)
                begin
                    $error("result_valid exp %0d got %0d", want.result_valid, got.result_valid);
                    errors++;
                end
                if (got.mean_period_us !== want.mean_period_us)
                begin
                    $error("mean_period_us exp %0d got %0d", want.mean_period_us, got.mean_period_us);
                    errors++;
                end
                if (got.frequency_mhz !== want.frequency_mhz)
                begin
                    $error("frequency_mhz exp %0d got %0d", want.frequency_mhz, got.frequency_mhz);
                    errors++;
                end
                if (got.phase_centideg !== want.phase_centideg)
                begin
                    $error("phase_centideg exp %0d got %0d", want.phase_centideg, got.phase_centideg);
                    errors++;
                end
                if (got.power_factor_q15 !== want.power_factor_q15)
                begin
                    $error("power_factor_q15 exp %0d got %0d", $signed(want.power_factor_q15),
                           $signed(got.power_factor_q15));
                    errors++;
                end
                if (got.cycles_seen !== want.cycles_seen)
                begin
                    $error("cycles_seen exp %0d got %0d", want.cycles_seen, got.cycles_seen);
                    errors++;
                end
            end
        end
    end

    logic [31:0] clock_us = 0;

    task automatic push_sample(input int v, input int i, input int dt);
        sample_t s;
        clock_us = clock_us + 32'(dt);
        s.voltage_code = 10'(v); s.current_code = 10'(i); s.time_us = clock_us;
        pending_samples.push_back(s);
    endtask

    // one sine-like period with a given current lag; n samples per period
    task automatic push_cycle(input int n, input int lag, input int amp, input int dt);
        int k, vv, ii;
        for (k = 0; k < n; k++)
        begin
            vv = 512 + ((k < n/2) ? amp * (1 + (k < n/4 ? k : n/2 - k)) / (n/4 + 1)
                                   : -amp * (1 + (k - n/2 < n/4 ? k - n/2 : n - k)) / (n/4 + 1));
            ii = ((k + lag) % n < n/2) ? 512 + amp * ((k + lag) % n + 1) / n : 512 - amp / 2;
            if (vv < 0) vv = 0;
            if (vv > 1023) vv = 1023;
            if (ii < 0) ii = 0;
            if (ii > 1023) ii = 1023;
            push_sample(vv, ii, dt);
        end
    endtask

    task automatic drain_and_idle();
        while (pending_samples.size() != 0 || s_axis_tvalid) @(posedge clk);
        hold_off = 1;
        while (expected_readings.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        hold_off = 0;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            REG_WINDOW:  win_len = val;
            REG_VOFFSET: v_off = $signed({{22{val[9]}}, val[9:0]});
            REG_IOFFSET: i_off = $signed({{22{val[9]}}, val[9:0]});
            default:     lag_floor = val;
        endcase
    endtask

    initial
    begin
        int ph, k, n;
        rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        cfg_we = 0; cfg_index = REG_WINDOW; cfg_data = 0;
        reset_meter_model();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, timestamp wrap, window of 0 and 12
        write_reg(REG_WINDOW, 16'd0);
        push_sample(0, 0, 0);
        push_sample(1023, 1023, 5);
        push_sample(0, 1023, 7);
        push_sample(1023, 0, 9);
        push_sample(512, 512, 3);
        push_sample(513, 511, 3);
        clock_us = 32'hFFFF_FFF0;
        push_sample(1023, 1023, 0);
        push_sample(0, 0, 40);
        push_sample(900, 700, 40);
        push_sample(0, 0, 32'h7FFF_FFFF);
        drain_and_idle();
        write_reg(REG_WINDOW, 16'd12);
        write_reg(REG_FLOOR, 16'd0);
        push_cycle(12, 2, 400, 100);
        push_cycle(12, 0, 400, 0);
        push_cycle(12, 11, 500, 1000);
        drain_and_idle();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_WINDOW, 16'd24); write_reg(REG_FLOOR, 16'd100); end
                1: begin write_reg(REG_VOFFSET, 16'h200); write_reg(REG_IOFFSET, 16'h1FF); end
                2: begin write_reg(REG_VOFFSET, 16'h1FF); write_reg(REG_IOFFSET, 16'h200); end
                3: begin write_reg(REG_VOFFSET, 16'h3F6); write_reg(REG_IOFFSET, 16'd5);
                         write_reg(REG_FLOOR, 16'hFFFF); end
                4: begin write_reg(REG_VOFFSET, 16'd0); write_reg(REG_IOFFSET, 16'd0);
                         write_reg(REG_FLOOR, 16'd0); write_reg(REG_WINDOW, 16'd1); end
                5: write_reg(REG_WINDOW, 16'd40);
                6: write_reg(REG_FLOOR, 16'($urandom_range(0, 3000)));
                default: write_reg(REG_WINDOW, 16'hFFFF);
            endcase
            if (ph == 7)
            begin
                for (k = 0; k < 20; k++) push_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                                     $urandom);
            end
            else
            begin
                for (k = 0; k < 5; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        for (n = 0; n < 6; n++)
                            push_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                        $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3000));
                    else
                        push_cycle(4 * $urandom_range(2, 5), $urandom_range(0, 19),
                                   $urandom_range(50, 511), $urandom_range(1, 2000));
                end
            end
            drain_and_idle();
        end
        // window 0xFFFF never closes here; return to a short window to flush
        write_reg(REG_WINDOW, 16'd1);
        push_sample(600, 600, 10);
        drain_and_idle();
        stim_done = 1;
        $display("Sent %0d samples over eleven register settings; checked %0d results.",
                 samples_sent, readings_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/pfpm_pkg.sv
src/pfpm_div.sv
src/pfpm_datapath.sv
src/pfpm_ctrl.sv
src/power_factor_phase_meter.sv
bench/testbench.sv
